>>> rtl/core/rcat_pkg.sv
package rcat_pkg;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_STEP  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_FINAL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_EXTEND = 2'd1,
    KIND_CZERO  = 2'd2,
    KIND_COMMIT = 2'd3
  } kind_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam int SID_W = 10;
  localparam int TGT_W = 11;
  localparam int CAP_W = 4;
  localparam int POS_W = 31;

  typedef struct packed {
    logic [1:0]       op;
    logic [SID_W-1:0] state_id;
    logic [1:0]       kind;
    logic [CAP_W-1:0] cap;
    logic [TGT_W-1:0] target;
    logic [SID_W-1:0] dest_state;
    logic [POS_W-1:0] offset;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CAP_W-1:0] capture_index;
    logic [POS_W-1:0] start_pos;
    logic [POS_W-1:0] end_pos;
    logic             capture_valid;
    logic [4:0]       group_count;
    logic             last;
  } res_t;

endpackage

>>> rtl/core/rcat_queue.sv
module rcat_queue import rcat_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

>>> rtl/core/rcat_exec.sv
module rcat_exec import rcat_pkg::*; #(
  parameter int ACTIONS  = 64,
  parameter int CAPTURES = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  cmd_t q_cmd,
  output logic q_pop,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_res
);

  localparam int AW = (ACTIONS > 1) ? $clog2(ACTIONS) : 1;
  localparam int CW = (CAPTURES > 1) ? $clog2(CAPTURES) : 1;
  localparam int NW = $clog2(ACTIONS + 1);
  localparam int EW = SID_W + 2 + CAP_W + TGT_W;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WAIT, S_APPLY, S_FIN, S_OUT} st_t;

  logic [EW-1:0]    tab_r [ACTIONS];
  logic [EW-1:0]    rd_r;
  logic [POS_W-1:0] cs_r [CAPTURES];
  logic [POS_W-1:0] ce_r [CAPTURES];
  logic [CAPTURES-1:0] ss_r, es_r, cm_r;
  logic [NW-1:0]    cnt_r;
  logic [CAP_W-1:0] hi_r;
  st_t              st_r;
  cmd_t             c_r;
  logic [NW-1:0]    i_r;
  logic [CW-1:0]    k_r;
  logic             dup_r;
  logic             ov_r;
  res_t             res_r;
  logic             wr_en;
  logic [AW-1:0]    rd_addr;

  logic [SID_W-1:0] e_own;
  logic [1:0]       e_kind;
  logic [CAP_W-1:0] e_cap;
  logic [TGT_W-1:0] e_tgt;
  logic [CW-1:0]    ci;
  logic             cap_ok;
  logic             nxt_eq;
  logic [4:0]       count_now;
  logic             done_out;
  logic [1:0]       add_st;
  logic [4:0]       add_cnt;
  logic             fin_v;

  assign {e_own, e_kind, e_cap, e_tgt} = rd_r;
  assign ci      = CW'(e_cap);
  assign cap_ok  = ({1'b0, e_cap} < (CAP_W+1)'(CAPTURES));
  assign nxt_eq  = (TGT_W'(c_r.dest_state) == e_tgt);
  assign count_now = (cnt_r == '0) ? 5'd0 : 5'(hi_r) + 5'd1;
  assign out_valid = (st_r == S_OUT);
  assign out_res   = res_r;
  assign done_out  = out_valid && !out_stall;
  assign q_pop     = (st_r == S_IDLE) && !q_empty;
  assign rd_addr   = i_r[AW-1:0];
  assign wr_en = (st_r == S_SCAN) && (i_r == cnt_r) && (c_r.op == OP_ADD) && !dup_r &&
                 ({1'b0, c_r.cap} < (CAP_W+1)'(CAPTURES)) && (cnt_r < NW'(ACTIONS));
  assign add_st  = (c_r.op != OP_ADD) ? ST_OK : (dup_r ? ST_DUP : (wr_en ? ST_OK : ST_FULL));
  assign add_cnt = wr_en ? (((c_r.cap > hi_r) ? 5'(c_r.cap) : 5'(hi_r)) + 5'd1) : count_now;
  assign fin_v   = ss_r[k_r] && es_r[k_r] && cm_r[k_r];

  always_ff @(posedge clk) begin
    if (wr_en) tab_r[cnt_r[AW-1:0]] <= {c_r.state_id, c_r.kind, c_r.cap, c_r.target};
    rd_r <= tab_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (st_r == S_APPLY && e_own == c_r.state_id && cap_ok) begin
      case (kind_t'(e_kind))
        KIND_START:  if (nxt_eq && !ss_r[ci]) cs_r[ci] <= c_r.offset;
        KIND_EXTEND: if (ss_r[ci] && !(es_r[ci] && cm_r[ci]) && nxt_eq) ce_r[ci] <= c_r.offset;
        KIND_CZERO: begin
          if (!ss_r[ci]) cs_r[ci] <= c_r.offset;
          ce_r[ci] <= c_r.offset;
        end
        default: ce_r[ci] <= c_r.offset;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
      hi_r <= '0;
      ss_r <= '0;
      es_r <= '0;
      cm_r <= '0;
      i_r <= '0;
      k_r <= '0;
      dup_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: if (!q_empty) begin
          c_r <= q_cmd;
          i_r <= '0;
          k_r <= '0;
          dup_r <= 1'b0;
          case (op_t'(q_cmd.op))
            OP_ADD, OP_STEP: st_r <= S_SCAN;
            OP_CLEAR: begin
              ss_r <= '0;
              es_r <= '0;
              cm_r <= '0;
              res_r <= '{default: '0, group_count: count_now, last: 1'b1};
              st_r <= S_OUT;
            end
            default: st_r <= S_FIN;
          endcase
        end
        S_SCAN: begin
          if (i_r == cnt_r) begin
            res_r <= '{default: '0, status: add_st, group_count: add_cnt, last: 1'b1};
            if (wr_en) begin
              cnt_r <= cnt_r + 1'b1;
              if (c_r.cap > hi_r) hi_r <= c_r.cap;
            end
            st_r <= S_OUT;
          end else st_r <= S_WAIT;
        end
        S_WAIT: begin
          i_r <= i_r + 1'b1;
          if (c_r.op == OP_ADD) begin
            if (rd_r == {c_r.state_id, c_r.kind, c_r.cap, c_r.target}) dup_r <= 1'b1;
            st_r <= S_SCAN;
          end else st_r <= S_APPLY;
        end
        S_APPLY: begin
          if (e_own == c_r.state_id && cap_ok) begin
            case (kind_t'(e_kind))
              KIND_START: if (nxt_eq && !ss_r[ci]) ss_r[ci] <= 1'b1;
              KIND_EXTEND: if (ss_r[ci] && !(es_r[ci] && cm_r[ci]) && nxt_eq) begin
                es_r[ci] <= 1'b1;
                cm_r[ci] <= 1'b0;
              end
              KIND_CZERO: begin
                ss_r[ci] <= 1'b1;
                es_r[ci] <= 1'b1;
                cm_r[ci] <= 1'b1;
              end
              default: begin
                es_r[ci] <= 1'b1;
                cm_r[ci] <= 1'b1;
              end
            endcase
          end
          st_r <= S_SCAN;
        end
        S_FIN: begin
          if (cnt_r == '0) begin
            res_r <= '{default: '0, last: 1'b1};
            ov_r <= 1'b0;
          end else begin
            res_r <= '{status: ST_OK, capture_index: CAP_W'(k_r),
                       start_pos: fin_v ? cs_r[k_r] : '0,
                       end_pos: fin_v ? ce_r[k_r] : '0,
                       capture_valid: fin_v, group_count: count_now,
                       last: (CAP_W'(k_r) == hi_r) || (32'(k_r) == CAPTURES - 1)};
            ov_r <= 1'b1;
          end
          st_r <= S_OUT;
        end
        S_OUT: if (done_out) begin
          if (ov_r && !res_r.last) begin
            k_r <= k_r + 1'b1;
            st_r <= S_FIN;
          end else begin
            ov_r <= 1'b0;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/regex_capture_action_tracker_top.sv
// Regex capture tracker.
// Input channel in_*: in_valid/in_stall, one command per item (add, step,
// clear, finalize). Result channel out_*: out_valid/out_stall.
// A two-entry queue decouples command intake from the executor, so intake
// continues while a result waits on out_stall.
// One item is executed at a time. Add scans the action table (S_SCAN,
// S_WAIT per stored action) for a duplicate, then appends unless it is a
// duplicate, the table is full or the capture number is out of range.
// Step reads each stored action (S_SCAN, S_WAIT, S_APPLY; single-port
// table read) and updates capture positions. Clear resets all capture
// flags. Finalize emits highest_capture_id+1 results (one if no actions).
// Reset (rst_n low, synchronous) empties the table, the queue, and all
// capture flags. A stalled result holds on the port until taken.
module regex_capture_action_tracker_top import rcat_pkg::*; #(
  parameter int ACTIONS  = 64,
  parameter int CAPTURES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_op,
  input  logic [SID_W-1:0] in_state_id,
  input  logic [1:0]       in_action_kind,
  input  logic [CAP_W-1:0] in_capture_num,
  input  logic [TGT_W-1:0] in_target_state,
  input  logic [SID_W-1:0] in_dest_state,
  input  logic [POS_W-1:0] in_offset,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_status,
  output logic [CAP_W-1:0] out_capture_index,
  output logic [POS_W-1:0] out_start_pos,
  output logic [POS_W-1:0] out_end_pos,
  output logic             out_capture_valid,
  output logic [4:0]       out_group_count,
  output logic             out_last
);

  cmd_t q_in, q_out;
  logic q_full, q_empty, q_pop;
  res_t res;

  assign q_in = '{op: in_op, state_id: in_state_id, kind: in_action_kind,
                  cap: in_capture_num, target: in_target_state,
                  dest_state: in_dest_state, offset: in_offset};
  assign in_stall = q_full;

  rcat_queue u_q (
    .clk(clk), .rst_n(rst_n), .push(in_valid), .din(q_in), .full(q_full),
    .pop(q_pop), .dout(q_out), .empty(q_empty)
  );

  rcat_exec #(.ACTIONS(ACTIONS), .CAPTURES(CAPTURES)) u_exec (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_cmd(q_out), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_res(res)
  );

  assign out_status        = res.status;
  assign out_capture_index = res.capture_index;
  assign out_start_pos     = res.start_pos;
  assign out_end_pos       = res.end_pos;
  assign out_capture_valid = res.capture_valid;
  assign out_group_count   = res.group_count;
  assign out_last          = res.last;

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("pop from empty queue");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(res)) else $error("result changed");
  a_valid_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_capture_valid |-> out_start_pos == '0 && out_end_pos == '0)
    else $error("positions without valid capture");

endmodule
